// ===== hdl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg: shared definitions for the packet deframer
// Result word layout, result kinds, parse phases and framing constants.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int MAX_BODY     = 4096;
  localparam int HDR_OVERHEAD = 10;
  localparam int TRAIL_BYTES  = 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = 13;

  typedef enum logic [1:0] {
    KIND_BODY      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_SIZE  = 6'b000001,
    PH_ID    = 6'b000010,
    PH_TYPE  = 6'b000100,
    PH_BODY  = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              body_byte;
    logic signed [31:0]      packet_id;
    logic signed [31:0]      packet_type;
    logic [CNT_W-1:0]        body_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_wr_t;

endpackage

// ===== hdl/lpd_parser.sv =====
// ----------------------------------------------------------------------------
// lpd_parser: framing front end
// Takes one stream byte per accepted word, tracks the packet phase and
// produces at most one result word for the queue behind it.
// ----------------------------------------------------------------------------
module lpd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               new_connection,
  output lpd_pkg::result_wr_t res
);

  lpd_pkg::phase_t             phase_r, phase_nxt;
  logic [lpd_pkg::CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [31:0]                 declared_size_r, declared_size_nxt;
  logic [31:0]                 held_id_r, held_id_nxt;
  logic [31:0]                 held_type_r, held_type_nxt;
  logic [lpd_pkg::CNT_W-1:0]   body_count_r, body_count_nxt;
  logic                        nul_found_r, nul_found_nxt;

  always_comb begin
    lpd_pkg::phase_t           ph_e;
    logic [lpd_pkg::CNT_W-1:0] cnt_e;
    logic [31:0]               size_e;
    logic [31:0]               id_e;
    logic [31:0]               type_e;
    logic [lpd_pkg::CNT_W-1:0] body_e;
    logic                      nul_e;
    logic [lpd_pkg::CNT_W-1:0] cnt_inc;
    logic [31:0]               shifted_b;
    logic [31:0]               size_asm;
    logic [lpd_pkg::CNT_W-1:0] body_len;
    logic                      last_field_byte;

    ph_e   = phase_r;
    cnt_e  = byte_count_r;
    size_e = declared_size_r;
    id_e   = held_id_r;
    type_e = held_type_r;
    body_e = body_count_r;
    nul_e  = nul_found_r;

    // A new connection restarts from a clean state with this byte as the
    // first byte of a size field.
    if (new_connection) begin
      ph_e   = lpd_pkg::PH_SIZE;
      cnt_e  = '0;
      size_e = '0;
      id_e   = '0;
      type_e = '0;
      body_e = '0;
      nul_e  = 1'b0;
    end

    cnt_inc         = cnt_e + lpd_pkg::CNT_W'(1);
    shifted_b       = 32'(data_byte) << {cnt_e[1:0], 3'b000};
    size_asm        = size_e | shifted_b;
    body_len        = size_e[lpd_pkg::CNT_W-1:0] - lpd_pkg::CNT_W'(lpd_pkg::HDR_OVERHEAD);
    last_field_byte = (cnt_e[1:0] == 2'd3);

    phase_nxt         = ph_e;
    byte_count_nxt    = cnt_e;
    declared_size_nxt = size_e;
    held_id_nxt       = id_e;
    held_type_nxt     = type_e;
    body_count_nxt    = body_e;
    nul_found_nxt     = nul_e;
    res               = '0;

    case (ph_e)
      lpd_pkg::PH_SIZE: begin
        declared_size_nxt = size_asm;
        byte_count_nxt    = cnt_inc;
        if (last_field_byte) begin
          byte_count_nxt = '0;
          if ($signed(size_asm) < $signed(32'(lpd_pkg::HDR_OVERHEAD)) ||
              $signed(size_asm) >
              $signed(32'(lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY))) begin
            phase_nxt     = lpd_pkg::PH_ERROR;
            res.valid     = 1'b1;
            res.data.kind = lpd_pkg::KIND_MALFORMED;
          end else begin
            held_id_nxt    = '0;
            held_type_nxt  = '0;
            body_count_nxt = '0;
            nul_found_nxt  = 1'b0;
            phase_nxt      = lpd_pkg::PH_ID;
          end
        end
      end
      lpd_pkg::PH_ID: begin
        held_id_nxt    = id_e | shifted_b;
        byte_count_nxt = cnt_inc;
        if (last_field_byte) begin
          byte_count_nxt = '0;
          phase_nxt      = lpd_pkg::PH_TYPE;
        end
      end
      lpd_pkg::PH_TYPE: begin
        held_type_nxt  = type_e | shifted_b;
        byte_count_nxt = cnt_inc;
        if (last_field_byte) begin
          byte_count_nxt = '0;
          phase_nxt      = (size_e == 32'(lpd_pkg::HDR_OVERHEAD)) ?
                           lpd_pkg::PH_TRAIL : lpd_pkg::PH_BODY;
        end
      end
      lpd_pkg::PH_BODY: begin
        // Everything after the first NUL is swallowed silently.
        if (!nul_e && data_byte != 8'd0) begin
          body_count_nxt       = body_e + lpd_pkg::CNT_W'(1);
          res.valid            = 1'b1;
          res.data.kind        = lpd_pkg::KIND_BODY;
          res.data.body_byte   = data_byte;
          res.data.packet_id   = id_e;
          res.data.packet_type = type_e;
        end else begin
          nul_found_nxt = 1'b1;
        end
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= body_len) begin
          byte_count_nxt = '0;
          phase_nxt      = lpd_pkg::PH_TRAIL;
        end
      end
      lpd_pkg::PH_TRAIL: begin
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= lpd_pkg::CNT_W'(lpd_pkg::TRAIL_BYTES)) begin
          res.valid            = 1'b1;
          res.data.kind        = lpd_pkg::KIND_DONE;
          res.data.packet_id   = id_e;
          res.data.packet_type = type_e;
          res.data.body_length = body_e;
          phase_nxt            = lpd_pkg::PH_SIZE;
          byte_count_nxt       = '0;
          declared_size_nxt    = '0;
          body_count_nxt       = '0;
          nul_found_nxt        = 1'b0;
        end
      end
      default: begin
        // Error phase: discard until a new connection is flagged.
      end
    endcase

    if (!accept) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lpd_pkg::PH_SIZE;
      byte_count_r    <= '0;
      declared_size_r <= '0;
      held_id_r       <= '0;
      held_type_r     <= '0;
      body_count_r    <= '0;
      nul_found_r     <= 1'b0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      declared_size_r <= declared_size_nxt;
      held_id_r       <= held_id_nxt;
      held_type_r     <= held_type_nxt;
      body_count_r    <= body_count_nxt;
      nul_found_r     <= nul_found_nxt;
    end
  end

endmodule

// ===== hdl/lpd_result_queue.sv =====
// ----------------------------------------------------------------------------
// lpd_result_queue: result buffer
// Short queue between the parser and the consumer; the oldest word is
// shown on the read side while the queue holds anything.
// ----------------------------------------------------------------------------
module lpd_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lpd_pkg::result_wr_t wr,
  input  logic                rd_en,
  output lpd_pkg::result_t    rd_data,
  output logic                full,
  output logic                empty
);

  lpd_pkg::result_t            entry_r [lpd_pkg::FIFO_DEPTH];
  logic [lpd_pkg::PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lpd_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lpd_pkg::PTR_W:0]     count_r, count_nxt;
  logic                        do_rd;

  assign full    = (count_r == (lpd_pkg::PTR_W+1)'(lpd_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr.valid ? wr_ptr_r + lpd_pkg::PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + lpd_pkg::PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (lpd_pkg::PTR_W+1)'(wr.valid) - (lpd_pkg::PTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      entry_r[wr_ptr_r] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/length_prefixed_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core: packet deframer top level
// Splits a size-prefixed byte stream into body bytes and completion words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while not full, set by the parse step.
// Each result is registered in the queue as its byte is taken.
// The four-word result queue lets the input run on while results wait; full
// rises only when four results are waiting.
// Synchronous active-low reset clears the parse state and empties the queue.
module length_prefixed_packet_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_data_byte,
  input  logic               in_new_connection,
  input  logic               push,
  output logic               full,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_body_byte,
  output logic signed [31:0] out_packet_id,
  output logic signed [31:0] out_packet_type,
  output logic [12:0]        out_body_length,
  output logic               empty,
  input  logic               pop
);

  lpd_pkg::result_wr_t res_wr;
  lpd_pkg::result_t    res_rd;
  logic                accept;

  assign accept = push && !full;

  lpd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .new_connection (in_new_connection),
    .res            (res_wr)
  );

  lpd_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .rd_en   (pop),
    .rd_data (res_rd),
    .full    (full),
    .empty   (empty)
  );

  assign out_result_kind = res_rd.kind;
  assign out_body_byte   = res_rd.body_byte;
  assign out_packet_id   = res_rd.packet_id;
  assign out_packet_type = res_rd.packet_type;
  assign out_body_length = res_rd.body_length;

endmodule

// ===== hdl/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker: port-level checks for the packet deframer
// Watches the top-level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic [1:0]         out_result_kind,
  input logic [7:0]         out_body_byte,
  input logic signed [31:0] out_packet_id,
  input logic signed [31:0] out_packet_type,
  input logic [12:0]        out_body_length,
  input logic               empty,
  input logic               pop
);

  // The queue cannot be full and empty at once.
  a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue shows full and empty together");

  // Reset leaves no result waiting.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // A waiting word that is not taken stays on the ports.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_result_kind) &&
                          $stable(out_body_byte) && $stable(out_body_length)))
    else $error("stalled result changed");

  // Only body words carry a byte, and malformed words carry nothing else.
  a_fields_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind != lpd_pkg::KIND_BODY) |->
      (out_body_byte == 8'd0 &&
       (out_result_kind != lpd_pkg::KIND_MALFORMED ||
        (out_packet_id == 32'sd0 && out_packet_type == 32'sd0 &&
         out_body_length == 13'd0))))
    else $error("result fields inconsistent with kind");

  // A body word never reports a length and always carries a nonzero byte.
  a_body_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == lpd_pkg::KIND_BODY) |->
      (out_body_length == 13'd0 && out_body_byte != 8'd0))
    else $error("body word malformed");

endmodule

bind length_prefixed_packet_deframer_core lpd_checker u_lpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .out_result_kind (out_result_kind),
  .out_body_byte   (out_body_byte),
  .out_packet_id   (out_packet_id),
  .out_packet_type (out_packet_type),
  .out_body_length (out_body_length),
  .empty           (empty),
  .pop             (pop)
);

// ===== tb/tb_length_prefixed_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer_core: self-checking bench for the deframer
// Feeds size-prefixed packets, broken packets and noise into the byte queue,
// predicts every body, completion and malformed word and checks each one in
// order as it is popped, with random idling on both sides and a long stall on the receiving side.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer_core;

  localparam int NUL_NONE = 1 << 30;
  localparam int FULL_LEN = 1 << 30;

  typedef struct {
    logic [7:0] data;
    logic       nc;
  } stream_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_new_connection = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         out_result_kind;
  logic [7:0]         out_body_byte;
  logic signed [31:0] out_packet_id;
  logic signed [31:0] out_packet_type;
  logic [12:0]        out_body_length;
  logic               empty;
  logic               pop = 1'b0;

  stream_word_t       byte_stream_q[$];
  lpd_pkg::result_t   expected_results[$];
  int                 queued_cnt = 0;
  int                 err_cnt = 0;
  bit                 no_idle = 1'b0;
  bit                 rx_hold = 1'b0;
  bit                 start_rx_hold = 1'b0;

  // Predictor state
  lpd_pkg::phase_t pr_phase = lpd_pkg::PH_SIZE;
  int unsigned     pr_byte_cnt = 0;
  logic [31:0]     pr_size = '0;
  logic [31:0]     pr_id = '0;
  logic [31:0]     pr_type = '0;
  logic [12:0]     pr_body_cnt = '0;
  bit              pr_nul_seen = 1'b0;

  length_prefixed_packet_deframer_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .in_new_connection (in_new_connection),
    .push              (push),
    .full              (full),
    .out_result_kind   (out_result_kind),
    .out_body_byte     (out_body_byte),
    .out_packet_id     (out_packet_id),
    .out_packet_type   (out_packet_type),
    .out_body_length   (out_body_length),
    .empty             (empty),
    .pop               (pop)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  // Advances the predicted parser by one accepted word and queues any result.
  task automatic deframe_byte(input logic [7:0] b, input logic nc);
    logic [4:0]       sh;
    lpd_pkg::result_t r;
    if (nc) begin
      pr_phase    = lpd_pkg::PH_SIZE;
      pr_byte_cnt = 0;
      pr_size     = '0;
      pr_id       = '0;
      pr_type     = '0;
      pr_body_cnt = '0;
      pr_nul_seen = 1'b0;
    end
    sh = {pr_byte_cnt[1:0], 3'b000};
    r  = '0;
    case (pr_phase)
      lpd_pkg::PH_SIZE: begin
        pr_size = pr_size | (32'(b) << sh);
        pr_byte_cnt++;
        if (pr_byte_cnt == 4) begin
          pr_byte_cnt = 0;
          if ($signed(pr_size) < lpd_pkg::HDR_OVERHEAD ||
              $signed(pr_size) > lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY) begin
            pr_phase = lpd_pkg::PH_ERROR;
            r.kind   = lpd_pkg::KIND_MALFORMED;
            expected_results.insert(expected_results.size(), r);
          end else begin
            pr_id       = '0;
            pr_type     = '0;
            pr_body_cnt = '0;
            pr_nul_seen = 1'b0;
            pr_phase    = lpd_pkg::PH_ID;
          end
        end
      end
      lpd_pkg::PH_ID: begin
        pr_id = pr_id | (32'(b) << sh);
        pr_byte_cnt++;
        if (pr_byte_cnt == 4) begin
          pr_byte_cnt = 0;
          pr_phase    = lpd_pkg::PH_TYPE;
        end
      end
      lpd_pkg::PH_TYPE: begin
        pr_type = pr_type | (32'(b) << sh);
        pr_byte_cnt++;
        if (pr_byte_cnt == 4) begin
          pr_byte_cnt = 0;
          pr_phase    = (pr_size == 32'(lpd_pkg::HDR_OVERHEAD)) ?
                        lpd_pkg::PH_TRAIL : lpd_pkg::PH_BODY;
        end
      end
      lpd_pkg::PH_BODY: begin
        // Once a NUL has been seen the rest of the body region is swallowed.
        if (!pr_nul_seen && b != 8'h00) begin
          pr_body_cnt++;
          r.kind        = lpd_pkg::KIND_BODY;
          r.body_byte   = b;
          r.packet_id   = pr_id;
          r.packet_type = pr_type;
          expected_results.insert(expected_results.size(), r);
        end else begin
          pr_nul_seen = 1'b1;
        end
        pr_byte_cnt++;
        if (32'(pr_byte_cnt) >= pr_size - 32'(lpd_pkg::HDR_OVERHEAD)) begin
          pr_byte_cnt = 0;
          pr_phase    = lpd_pkg::PH_TRAIL;
        end
      end
      lpd_pkg::PH_TRAIL: begin
        pr_byte_cnt++;
        if (pr_byte_cnt >= lpd_pkg::TRAIL_BYTES) begin
          r.kind        = lpd_pkg::KIND_DONE;
          r.packet_id   = pr_id;
          r.packet_type = pr_type;
          r.body_length = pr_body_cnt;
          expected_results.insert(expected_results.size(), r);
          pr_phase    = lpd_pkg::PH_SIZE;
          pr_byte_cnt = 0;
          pr_size     = '0;
          pr_body_cnt = '0;
          pr_nul_seen = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic put_byte(input logic [7:0] b, input logic nc);
    stream_word_t w;
    w.data = b;
    w.nc   = nc;
    byte_stream_q.insert(byte_stream_q.size(), w);
    queued_cnt++;
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Builds one packet and queues its first cut bytes; a size outside the legal
  // range yields just the size field. Bytes before nul_at are never zero.
  task automatic queue_packet(input logic [31:0] pkt_size, input logic [31:0] id,
                              input logic [31:0] typ, input int nul_at,
                              input bit fresh, input int cut);
    logic [7:0] pkt[$];
    int         region;
    bit         size_ok;
    for (int i = 0; i < 4; i++) pkt.insert(pkt.size(), pkt_size[8*i +: 8]);
    size_ok = !($signed(pkt_size) < lpd_pkg::HDR_OVERHEAD ||
                $signed(pkt_size) > lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY);
    if (size_ok) begin
      region = int'(pkt_size) - lpd_pkg::HDR_OVERHEAD;
      for (int i = 0; i < 4; i++) pkt.insert(pkt.size(), id[8*i +: 8]);
      for (int i = 0; i < 4; i++) pkt.insert(pkt.size(), typ[8*i +: 8]);
      for (int i = 0; i < region; i++) begin
        pkt.insert(pkt.size(), (i < nul_at) ? 8'($urandom_range(1, 255)) :
                   ((i == nul_at) ? 8'h00 : 8'($urandom_range(0, 255))));
      end
      for (int i = 0; i < lpd_pkg::TRAIL_BYTES; i++) begin
        pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < pkt.size() && i < cut; i++) put_byte(pkt[i], fresh && i == 0);
  endtask

  task automatic random_traffic(input int n_bytes);
    int          stop_at;
    int          pick;
    int          pkt_size;
    logic [31:0] bad;
    bit          need_fresh;
    // The parser may have been left anywhere by the previous phase.
    need_fresh = 1'b1;
    stop_at    = queued_cnt + n_bytes;
    while (queued_cnt < stop_at) begin
      pick     = $urandom_range(0, 99);
      pkt_size = lpd_pkg::HDR_OVERHEAD + (($urandom_range(0, 39) == 0) ?
                                          $urandom_range(0, 300) : $urandom_range(0, 24));
      if (pick < 75) begin
        queue_packet(pkt_size, $urandom, $urandom,
                     $urandom_range(0, 1) ?
                       $urandom_range(0, pkt_size - lpd_pkg::HDR_OVERHEAD) : NUL_NONE,
                     need_fresh || $urandom_range(0, 9) == 0, FULL_LEN);
        need_fresh = 1'b0;
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       bad = $urandom_range(0, lpd_pkg::HDR_OVERHEAD - 1);
          1:       bad = lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY + 1 +
                         $urandom_range(0, 100);
          2:       bad = $urandom | 32'h8000_0000;
          default: bad = ($urandom | 32'h0100_0000) & 32'h7FFF_FFFF;
        endcase
        queue_packet(bad, $urandom, $urandom, NUL_NONE,
                     need_fresh || $urandom_range(0, 1) == 0, FULL_LEN);
        queue_noise($urandom_range(0, 12));
        need_fresh = 1'b1;
      end else if (pick < 95) begin
        queue_packet(pkt_size, $urandom, $urandom, NUL_NONE, need_fresh,
                     $urandom_range(1, pkt_size + 1));
        need_fresh = 1'b1;
      end else begin
        queue_noise($urandom_range(1, 8));
        need_fresh = 1'b1;
      end
    end
  endtask

  task automatic drain();
    while (byte_stream_q.size() != 0 || expected_results.size() != 0) @(negedge clk);
  endtask

  // Sender: offers the oldest pending word, idling now and then.
  always @(negedge clk) begin
    if (!rst_n || byte_stream_q.size() == 0 || (!no_idle && $urandom_range(0, 99) < 18)) begin
      push <= 1'b0;
    end else begin
      push              <= 1'b1;
      in_data_byte      <= byte_stream_q[0].data;
      in_new_connection <= byte_stream_q[0].nc;
    end
  end

  // Receiver: pops at random, or not at all while a long hold-off runs.
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      pop <= 1'b0;
    end else begin
      pop <= no_idle || $urandom_range(0, 99) >= 18;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      deframe_byte(in_data_byte, in_new_connection);
      void'(byte_stream_q.pop_front());
    end
  end

  always @(posedge clk) begin : check_results
    lpd_pkg::result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d", out_result_kind));
      end else begin
        want = expected_results.pop_front();
        if (out_result_kind != want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d", out_result_kind, want.kind));
        if (out_body_byte != want.body_byte)
          report_mismatch($sformatf("body_byte %0h, want %0h", out_body_byte, want.body_byte));
        if (out_packet_id != want.packet_id)
          report_mismatch($sformatf("packet_id %0d, want %0d", out_packet_id, want.packet_id));
        if (out_packet_type != want.packet_type)
          report_mismatch($sformatf("packet_type %0d, want %0d", out_packet_type,
                                    want.packet_type));
        if (out_body_length != want.body_length)
          report_mismatch($sformatf("body_length %0d, want %0d", out_body_length,
                                    want.body_length));
      end
    end
  end

  // Holds the receiver off long enough for the result queue to fill and
  // push back on the input.
  initial begin
    wait (start_rx_hold);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty body region and a single body byte, with id and type at extremes.
    queue_packet(32'd10, 32'h7FFF_FFFF, 32'h8000_0000, NUL_NONE, 1'b1, FULL_LEN);
    queue_packet(32'd11, 32'h8000_0000, 32'h7FFF_FFFF, NUL_NONE, 1'b0, FULL_LEN);
    queue_packet(32'd16, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0, FULL_LEN);
    // A NUL early in the body, followed by bytes that must be dropped.
    queue_packet(32'd20, 32'h0000_0000, 32'hFFFF_FFFF, 3, 1'b0, FULL_LEN);
    // A new connection in the middle of the id field restarts parsing.
    queue_packet(32'd20, $urandom, $urandom, NUL_NONE, 1'b0, 7);
    queue_packet(32'd12, $urandom, $urandom, NUL_NONE, 1'b1, FULL_LEN);
    // Sizes just outside the legal range and at the signed extremes; the
    // bytes that follow are discarded until the next new connection.
    queue_packet(32'd9, $urandom, $urandom, NUL_NONE, 1'b0, FULL_LEN);
    queue_noise(6);
    queue_packet(32'(lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY + 1), $urandom, $urandom,
                 NUL_NONE, 1'b1, FULL_LEN);
    queue_noise(6);
    queue_packet(32'h8000_0000, $urandom, $urandom, NUL_NONE, 1'b1, FULL_LEN);
    queue_noise(3);
    queue_packet(32'h7FFF_FFFF, $urandom, $urandom, NUL_NONE, 1'b1, FULL_LEN);
    queue_packet(32'hFFFF_FFFF, $urandom, $urandom, NUL_NONE, 1'b1, FULL_LEN);
    queue_packet(32'h0000_0000, $urandom, $urandom, NUL_NONE, 1'b1, FULL_LEN);
    // The largest legal size is accepted; the packet is cut short in its body.
    queue_packet(32'(lpd_pkg::HDR_OVERHEAD + lpd_pkg::MAX_BODY), $urandom, $urandom,
                 NUL_NONE, 1'b1, 40);
    drain();

    random_traffic(400);
    drain();

    no_idle = 1'b1;
    random_traffic(250);
    drain();
    no_idle = 1'b0;

    start_rx_hold = 1'b1;
    random_traffic(450);
    drain();

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
